[rtl/button_press_classifier_unit_macros.svh]
// assertion macros shared by the button press classifier rtl
`ifndef BUTTON_PRESS_CLASSIFIER_UNIT_MACROS_SVH
`define BUTTON_PRESS_CLASSIFIER_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define BPC_ASSERT_NOW(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define BPC_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

[rtl/bpc_pkg.sv]
// types and constants of the button press classifier
package bpc_pkg;

   // fixed field widths
   localparam int BTN_W     = 5;
   localparam int CFG_W     = 16;
   localparam int CSR_IDX_W = 2;

   // register reset values
   localparam logic [CFG_W-1:0] DEBOUNCE_TICKS_RST = 16'd10;
   localparam logic [CFG_W-1:0] SHORT_TICKS_RST    = 16'd250;
   localparam logic [CFG_W-1:0] LONG_TICKS_RST     = 16'd3000;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_DEBOUNCE_TICKS = 2'd0,
      REG_SHORT_TICKS    = 2'd1,
      REG_LONG_TICKS     = 2'd2
   } csr_reg_type;

   // per-button press phase
   typedef enum logic [1:0] {
      PH_IDLE     = 2'd0,
      PH_DEBOUNCE = 2'd1,
      PH_SHORT    = 2'd2,
      PH_HELD     = 2'd3
   } phase_type;

   // what one lane found in one beat
   typedef struct packed {
      logic short_hit;
      logic long_hit;
   } lane_hit_type;

endpackage

[rtl/bpc_if.sv]
// valid/ready channels of the button press classifier
interface bpc_req_if import bpc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             tick;
   logic [BTN_W-1:0] buttons;
   logic             clear_flags;

   modport source (output valid, tick, buttons, clear_flags, input ready);
   modport sink   (input valid, tick, buttons, clear_flags, output ready);
endinterface

interface bpc_rsp_if import bpc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [BTN_W-1:0] short_flags;
   logic [BTN_W-1:0] long_flags;

   modport source (output valid, short_flags, long_flags, input ready);
   modport sink   (input valid, short_flags, long_flags, output ready);
endinterface

[rtl/bpc_lane.sv]
// one button: press phase machine and its three down-counting timers
module bpc_lane import bpc_pkg::*; #(
   parameter int TIMER_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic                  tick,
   input  logic                  pressed,
   input  logic [TIMER_BITS-1:0] deb_load,
   input  logic [TIMER_BITS-1:0] short_load,
   input  logic [TIMER_BITS-1:0] long_load,
   output lane_hit_type          hit
);

   phase_type             phase_ff, phase_in;
   logic [TIMER_BITS-1:0] deb_ff, deb_in;
   logic [TIMER_BITS-1:0] short_ff, short_in;
   logic [TIMER_BITS-1:0] long_ff, long_in;
   logic [TIMER_BITS-1:0] deb_dec, short_dec, long_dec;

   // tick: every running timer drops by one
   always_comb begin
      deb_dec   = (tick && deb_ff != '0)   ? deb_ff - 1'b1   : deb_ff;
      short_dec = (tick && short_ff != '0) ? short_ff - 1'b1 : short_ff;
      long_dec  = (tick && long_ff != '0)  ? long_ff - 1'b1  : long_ff;
   end

   // phase update on the decremented timers
   always_comb begin
      phase_in      = phase_ff;
      deb_in        = deb_dec;
      short_in      = short_dec;
      long_in       = long_dec;
      hit.short_hit = 1'b0;
      hit.long_hit  = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            if (pressed) begin
               deb_in   = deb_load;
               short_in = short_load;
               long_in  = long_load;
               phase_in = PH_DEBOUNCE;
            end
         end
         PH_DEBOUNCE: begin
            if (deb_dec == '0) phase_in = pressed ? PH_SHORT : PH_IDLE;
         end
         PH_SHORT: begin
            if (short_dec == '0) begin
               if (pressed) begin
                  phase_in = PH_HELD;
               end else begin
                  hit.short_hit = 1'b1;
                  phase_in      = PH_IDLE;
               end
            end
         end
         PH_HELD: begin
            if (!pressed) begin
               hit.long_hit  = (long_dec == '0);
               hit.short_hit = (long_dec != '0);
               phase_in      = PH_IDLE;
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   // state registers advance once per accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         deb_ff   <= '0;
         short_ff <= '0;
         long_ff  <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         deb_ff   <= deb_in;
         short_ff <= short_in;
         long_ff  <= long_in;
      end
   end

endmodule

[rtl/bpc_merge.sv]
// merge of lane results into the sticky short and long flag sets
module bpc_merge import bpc_pkg::*; #(
   parameter int LANES = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic             clear,
   input  lane_hit_type     hits [LANES],
   output logic [BTN_W-1:0] short_flags,
   output logic [BTN_W-1:0] long_flags
);

   logic [BTN_W-1:0] short_set, long_set;
   logic [BTN_W-1:0] short_ff, short_in;
   logic [BTN_W-1:0] long_ff, long_in;

   // gather lane hits into flag-wide vectors
   always_comb begin
      short_set = '0;
      long_set  = '0;
      for (int i = 0; i < LANES; i++) begin
         short_set[i] = hits[i].short_hit;
         long_set[i]  = hits[i].long_hit;
      end
   end

   // clear first, then raise this beat's flags
   always_comb begin
      short_in = (clear ? '0 : short_ff) | short_set;
      long_in  = (clear ? '0 : long_ff) | long_set;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         short_ff <= '0;
         long_ff  <= '0;
      end else if (step) begin
         short_ff <= short_in;
         long_ff  <= long_in;
      end
   end

   assign short_flags = short_ff;
   assign long_flags  = long_ff;

endmodule

[rtl/button_press_classifier_unit.sv]
// top level of the button press classifier
//
// Usage: each req beat carries the sampled button levels, a millisecond
// tick and a clear request; each req beat yields exactly one rsp beat with
// the sticky short and long press flags as they stand after that beat.
// Every button has its own lane (phase machine and three timers) and all
// lanes step together in the cycle the req beat is taken; a merge stage
// folds the lane results into the flag registers, which drive rsp directly.
// The rsp beat is valid in the cycle after the req beat is taken.
// Throughput: one beat per cycle while rsp does not stall, bounded by the single rsp register.
// When the rsp side stalls, the rsp beat holds and req ready drops until
// it is taken; outside reset, req ready is high whenever the rsp register
// is empty or being drained in the same cycle.
// Reset (synchronous): all buttons idle, timers and flags zero, the
// registers back to debounce 10, short 250, long 3000 ticks.
// Configuration: csr_we writes csr_wdata to register csr_index (0 debounce,
// 1 short, 2 long); other indexes are ignored. Write only when idle.
`include "button_press_classifier_unit_macros.svh"

module button_press_classifier_unit import bpc_pkg::*; #(
   parameter int NUM_BUTTONS = 5,
   parameter int TIMER_BITS  = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   bpc_req_if.sink              req_bus,
   bpc_rsp_if.source            rsp_bus,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   localparam int LANES = (NUM_BUTTONS < BTN_W) ? NUM_BUTTONS : BTN_W;

   logic [CFG_W-1:0]      deb_ticks_ff, short_ticks_ff, long_ticks_ff;
   logic [TIMER_BITS-1:0] deb_load, short_load, long_load;
   logic                  rsp_valid_ff;
   logic                  req_fire;
   lane_hit_type          hits [LANES];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         deb_ticks_ff   <= DEBOUNCE_TICKS_RST;
         short_ticks_ff <= SHORT_TICKS_RST;
         long_ticks_ff  <= LONG_TICKS_RST;
      end else if (csr_we) begin
         case (csr_index)
            REG_DEBOUNCE_TICKS: deb_ticks_ff   <= csr_wdata;
            REG_SHORT_TICKS:    short_ticks_ff <= csr_wdata;
            REG_LONG_TICKS:     long_ticks_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // timer load values, saturated to the timer width
   generate
      if (TIMER_BITS >= CFG_W) begin : g_wide_timer
         assign deb_load   = TIMER_BITS'(deb_ticks_ff);
         assign short_load = TIMER_BITS'(short_ticks_ff);
         assign long_load  = TIMER_BITS'(long_ticks_ff);
      end else begin : g_narrow_timer
         localparam logic [CFG_W-1:0] SAT = CFG_W'({TIMER_BITS{1'b1}});
         assign deb_load   = (deb_ticks_ff > SAT)   ? '1 : TIMER_BITS'(deb_ticks_ff);
         assign short_load = (short_ticks_ff > SAT) ? '1 : TIMER_BITS'(short_ticks_ff);
         assign long_load  = (long_ticks_ff > SAT)  ? '1 : TIMER_BITS'(long_ticks_ff);
      end
   endgenerate

   // handshake: take a req beat whenever the rsp register can move on
   assign req_bus.ready = !reset && (!rsp_valid_ff || rsp_bus.ready);
   assign req_fire      = req_bus.valid && req_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // one lane per button, at most BTN_W lanes
   generate
      for (genvar i = 0; i < LANES; i++) begin : g_lane
         bpc_lane #(
            .TIMER_BITS (TIMER_BITS)
         ) u_lane (
            .clock      (clock),
            .reset      (reset),
            .step       (req_fire),
            .tick       (req_bus.tick),
            .pressed    (req_bus.buttons[i]),
            .deb_load   (deb_load),
            .short_load (short_load),
            .long_load  (long_load),
            .hit        (hits[i])
         );
      end
   endgenerate

   // flag merge, its registers drive the rsp payload
   bpc_merge #(
      .LANES (LANES)
   ) u_merge (
      .clock       (clock),
      .reset       (reset),
      .step        (req_fire),
      .clear       (req_bus.clear_flags),
      .hits        (hits),
      .short_flags (rsp_bus.short_flags),
      .long_flags  (rsp_bus.long_flags)
   );

   assign rsp_bus.valid = rsp_valid_ff;

   // checks
   `BPC_ASSERT_NEXT(a_fire_gives_rsp, clock, reset, req_fire, rsp_valid_ff,
      "accepted req beat did not produce a rsp beat")
   `BPC_ASSERT_NEXT(a_flags_hold, clock, reset, !req_fire,
      $stable(rsp_bus.short_flags) && $stable(rsp_bus.long_flags),
      "flags changed without an accepted req beat")
   `BPC_ASSERT_NEXT(a_flags_sticky, clock, reset, req_fire && !req_bus.clear_flags,
      ((rsp_bus.short_flags & $past(rsp_bus.short_flags)) == $past(rsp_bus.short_flags))
      && ((rsp_bus.long_flags & $past(rsp_bus.long_flags)) == $past(rsp_bus.long_flags)),
      "flag dropped without a clear request")
   `BPC_ASSERT_NOW(a_no_take_on_stall, clock, reset, rsp_valid_ff && !rsp_bus.ready,
      !req_fire, "req beat taken while rsp beat stalled")

endmodule
